// ===== rtl/key_autorepeat_qualifier_top_defines.svh =====
// ----------------------------------------------------------------------------
// Key auto-repeat qualifier: assertion macros
// Shared property forms for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef KEY_AUTOREPEAT_QUALIFIER_TOP_DEFINES_SVH
`define KEY_AUTOREPEAT_QUALIFIER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define KAQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define KAQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/kaq_pkg.sv =====
// ----------------------------------------------------------------------------
// Key auto-repeat qualifier package
// Register widths, register indexes and shared types.
// ----------------------------------------------------------------------------
package kaq_pkg;

  // Width of every configuration register and of the 16-bit payload fields.
  localparam int CFG_BITS   = 16;
  localparam int INDEX_BITS = 3;

  // Configuration register indexes.
  localparam logic [INDEX_BITS-1:0] REG_PRESS_THRESHOLD = 3'd0;
  localparam logic [INDEX_BITS-1:0] REG_HOLD_DELAY      = 3'd1;
  localparam logic [INDEX_BITS-1:0] REG_REPEAT_INITIAL  = 3'd2;
  localparam logic [INDEX_BITS-1:0] REG_REPEAT_PERIOD   = 3'd3;
  localparam logic [INDEX_BITS-1:0] REG_RELEASE_MAX     = 3'd4;

  // Reset values of the configuration registers.
  localparam logic [CFG_BITS-1:0] RST_PRESS_THRESHOLD = 16'd0;
  localparam logic [CFG_BITS-1:0] RST_HOLD_DELAY      = 16'd0;
  localparam logic [CFG_BITS-1:0] RST_REPEAT_INITIAL  = 16'd30;
  localparam logic [CFG_BITS-1:0] RST_REPEAT_PERIOD   = 16'd6;
  localparam logic [CFG_BITS-1:0] RST_RELEASE_MAX     = 16'hFFFF;

  // A release limit of all ones means no limit.
  localparam logic [CFG_BITS-1:0] RELEASE_UNLIMITED = 16'hFFFF;

  // Status of the remainder unit.
  typedef struct packed {
    logic busy;
    logic done;
  } kaq_div_status_t;

  // One result.
  typedef struct packed {
    logic                clicked;
    logic                held;
    logic                pulsed;
    logic                released;
    logic [CFG_BITS-1:0] ticks_active;
    logic [CFG_BITS-1:0] ticks_inactive;
  } kaq_result_t;

endpackage

// ===== rtl/kaq_remainder.sv =====
// ----------------------------------------------------------------------------
// Key auto-repeat qualifier: remainder unit
// Restoring bit-serial remainder, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module kaq_remainder import kaq_pkg::*; #(
  parameter int DIVIDEND_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [DIVIDEND_BITS-1:0] dividend,
  input  logic [CFG_BITS-1:0]      divisor,
  output kaq_div_status_t          status,
  output logic [CFG_BITS-1:0]      remainder
);

  localparam int STEP_BITS = $clog2(DIVIDEND_BITS + 1);

  logic [DIVIDEND_BITS-1:0] dvd;
  logic [CFG_BITS-1:0]      dsr;
  logic [CFG_BITS-1:0]      rem;
  logic [CFG_BITS-1:0]      rem_next;
  logic [STEP_BITS-1:0]     steps;
  logic                     busy;
  logic                     done;
  logic [CFG_BITS:0]        trial;
  logic                     fits;

  // The partial remainder stays below the divisor, so the trial value
  // fits in one bit more than the divisor.
  always_comb begin
    trial    = {rem, dvd[DIVIDEND_BITS-1]};
    fits     = (trial >= {1'b0, dsr});
    rem_next = fits ? CFG_BITS'(trial - {1'b0, dsr}) : trial[CFG_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      done  <= 1'b0;
      steps <= STEP_BITS'(DIVIDEND_BITS);
    end else if (busy) begin
      steps <= steps - STEP_BITS'(1);
      if (steps == STEP_BITS'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      dsr <= divisor;
      rem <= '0;
    end else if (busy) begin
      dvd <= {dvd[DIVIDEND_BITS-2:0], 1'b0};
      rem <= rem_next;
    end
  end

  assign status.busy = busy;
  assign status.done = done;
  assign remainder   = rem;

endmodule

// ===== rtl/key_autorepeat_qualifier_top.sv =====
// ----------------------------------------------------------------------------
// Key auto-repeat qualifier
// Qualifies a sampled key level into click, held, repeat pulse and release.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake               Payload
//   -------   ---------------------   ---------------------------------------
//   input     in_valid / in_stall     level, clear
//   output    out_valid / out_stall   clicked, held, pulsed, released,
//                                     ticks_active, ticks_inactive
//   config    cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One request is taken every cycle while in_stall is low; its result enters
// the output register on the next cycle, or the skid register while a
// stalled result waits there. The whole update is one pass of compares and
// increments between the state registers and the result register.
// Reset clears levels, counters and the repeat phase and loads the register
// reset values. A two-entry output queue (output register plus skid register)
// lets a request in while one result waits; in_stall rises when both are
// full, and while a bit-serial remainder unit rebuilds the repeat phase after
// a write of repeat_period_ticks, until the rebuilt phase is loaded.
// ----------------------------------------------------------------------------
module key_autorepeat_qualifier_top import kaq_pkg::*; #(
  parameter int COUNT_BITS = 16,
  parameter int LEVEL_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  // Input channel.
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [CFG_BITS-1:0]   level,
  input  logic                  clear,
  // Output channel.
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  clicked,
  output logic                  held,
  output logic                  pulsed,
  output logic                  released,
  output logic [CFG_BITS-1:0]   ticks_active,
  output logic [CFG_BITS-1:0]   ticks_inactive,
  // Configuration write channel.
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_BITS-1:0]   cfg_data
);

  // Only the low LEVEL_BITS of the level and threshold take part, and never
  // more than the 16 bits that the ports carry.
  localparam int LVL_W    = (LEVEL_BITS < CFG_BITS) ? LEVEL_BITS : CFG_BITS;
  // Width in which counts are compared against the 16-bit registers.
  localparam int EXT_BITS = (COUNT_BITS > CFG_BITS) ? COUNT_BITS : CFG_BITS;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

  // Configuration registers.
  logic [CFG_BITS-1:0] press_threshold;
  logic [CFG_BITS-1:0] hold_delay_ticks;
  logic [CFG_BITS-1:0] repeat_initial_ticks;
  logic [CFG_BITS-1:0] repeat_period_ticks;
  logic [CFG_BITS-1:0] release_max_ticks;

  // Qualifier state.
  logic [LVL_W-1:0]      level_now;
  logic [LVL_W-1:0]      level_before;
  logic [COUNT_BITS-1:0] active_count;
  logic [COUNT_BITS-1:0] active_count_before;
  logic [COUNT_BITS-1:0] inactive_count;
  logic [CFG_BITS-1:0]   repeat_phase;

  logic [LVL_W-1:0]      level_now_next;
  logic [LVL_W-1:0]      level_before_next;
  logic [COUNT_BITS-1:0] active_count_next;
  logic [COUNT_BITS-1:0] active_count_before_next;
  logic [COUNT_BITS-1:0] inactive_count_next;
  logic [CFG_BITS-1:0]   repeat_phase_next;

  // Output queue.
  kaq_result_t result;
  kaq_result_t out_reg;
  kaq_result_t skid;
  logic        skid_valid;

  // Remainder unit hookup.
  kaq_div_status_t       div_status;
  logic [CFG_BITS-1:0]   div_remainder;
  logic                  period_write;
  logic [CFG_BITS-1:0]   cfg_period_eff;

  logic                  accept;
  logic                  take;
  logic                  cfg_write;

  logic [LVL_W-1:0]      threshold;
  logic [CFG_BITS-1:0]   period_eff;
  logic [CFG_BITS-1:0]   initial_eff;
  logic                  on_prev;
  logic                  on_in;
  logic                  on_new;
  logic                  was_new;
  logic                  click;
  logic                  active_at_max;
  logic                  inactive_at_max;
  logic [CFG_BITS:0]     phase_inc;
  logic [EXT_BITS-1:0]   ac_ext;
  logic [EXT_BITS-1:0]   acb_ext;
  logic [EXT_BITS-1:0]   ic_ext;
  logic                  repeat_ok;
  logic                  repeat_hit;

  // --------------------------------------------------------------------------
  // Handshakes. Requests wait while both queue entries are full or while the
  // repeat phase is being rebuilt after a period change, including the cycle
  // in which the rebuilt phase is loaded.
  // --------------------------------------------------------------------------
  assign in_stall  = skid_valid | div_status.busy | div_status.done;
  assign cfg_ready = ~div_status.busy;
  assign accept    = in_valid & ~in_stall;
  assign take      = out_valid & ~out_stall;
  assign cfg_write = cfg_valid & cfg_ready;

  // --------------------------------------------------------------------------
  // Configuration registers.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      press_threshold      <= RST_PRESS_THRESHOLD;
      hold_delay_ticks     <= RST_HOLD_DELAY;
      repeat_initial_ticks <= RST_REPEAT_INITIAL;
      repeat_period_ticks  <= RST_REPEAT_PERIOD;
      release_max_ticks    <= RST_RELEASE_MAX;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_PRESS_THRESHOLD: press_threshold      <= cfg_data;
        REG_HOLD_DELAY:      hold_delay_ticks     <= cfg_data;
        REG_REPEAT_INITIAL:  repeat_initial_ticks <= cfg_data;
        REG_REPEAT_PERIOD:   repeat_period_ticks  <= cfg_data;
        REG_RELEASE_MAX:     release_max_ticks    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Repeat phase rebuild. The phase tracks active_count modulo the period
  // incrementally; when the period changes, it is recomputed from the count
  // that the block holds at that moment.
  // --------------------------------------------------------------------------
  assign period_write   = cfg_write & (cfg_index == REG_REPEAT_PERIOD);
  assign cfg_period_eff = (cfg_data == '0) ? CFG_BITS'(1) : cfg_data;

  kaq_remainder #(
    .DIVIDEND_BITS (COUNT_BITS)
  ) u_remainder (
    .clk       (clk),
    .rst       (rst),
    .start     (period_write),
    .dividend  (active_count),
    .divisor   (cfg_period_eff),
    .status    (div_status),
    .remainder (div_remainder)
  );

  // --------------------------------------------------------------------------
  // State update for one request.
  // --------------------------------------------------------------------------
  always_comb begin
    threshold   = press_threshold[LVL_W-1:0];
    period_eff  = (repeat_period_ticks == '0) ? CFG_BITS'(1) : repeat_period_ticks;
    initial_eff = (repeat_initial_ticks == '0) ? CFG_BITS'(1) : repeat_initial_ticks;

    active_at_max   = (active_count == CNT_MAX);
    inactive_at_max = (inactive_count == CNT_MAX);
    phase_inc       = {1'b0, repeat_phase} + (CFG_BITS + 1)'(1);

    // Level of this request against the level that becomes "before".
    on_prev = (level_now > threshold);
    on_in   = (level[LVL_W-1:0] > threshold);

    level_now_next           = level[LVL_W-1:0];
    level_before_next        = level_now;
    active_count_next        = '0;
    active_count_before_next = '0;
    inactive_count_next      = inactive_at_max ? inactive_count
                                               : inactive_count + COUNT_BITS'(1);
    repeat_phase_next        = '0;

    if (clear) begin
      level_now_next      = '0;
      level_before_next   = '0;
      inactive_count_next = '0;
    end else if (on_in && !on_prev) begin
      // Press edge: counts restart, the inactive count still advances.
    end else if (on_in || on_prev) begin
      // Held, or the release tick, which still counts as active.
      active_count_before_next = active_count;
      active_count_next        = active_at_max ? active_count
                                               : active_count + COUNT_BITS'(1);
      inactive_count_next      = '0;
      if (active_at_max) begin
        repeat_phase_next = repeat_phase;
      end else if (phase_inc == {1'b0, period_eff}) begin
        repeat_phase_next = '0;
      end else begin
        repeat_phase_next = phase_inc[CFG_BITS-1:0];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result of one request, judged on the updated state.
  // --------------------------------------------------------------------------
  always_comb begin
    on_new  = (level_now_next > threshold);
    was_new = (level_before_next > threshold);
    click   = on_new & ~was_new;

    ac_ext  = EXT_BITS'(active_count_next);
    acb_ext = EXT_BITS'(active_count_before_next);
    ic_ext  = EXT_BITS'(inactive_count_next);

    // A repeat needs a count that moved on from a nonzero value.
    repeat_ok  = on_new & (acb_ext != '0) & (ac_ext != acb_ext);
    repeat_hit = (ac_ext > EXT_BITS'(initial_eff)) ? (repeat_phase_next == '0)
                                                   : (ac_ext == EXT_BITS'(initial_eff));

    result.clicked        = click;
    result.held           = on_new & (ac_ext >= EXT_BITS'(hold_delay_ticks));
    result.pulsed         = click | (repeat_ok & repeat_hit);
    result.released       = ~on_new & was_new &
                            ((release_max_ticks == RELEASE_UNLIMITED) ||
                             (ac_ext <= EXT_BITS'(release_max_ticks)));
    result.ticks_active   = ac_ext[CFG_BITS-1:0];
    result.ticks_inactive = ic_ext[CFG_BITS-1:0];
  end

  // --------------------------------------------------------------------------
  // State registers.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      level_now           <= '0;
      level_before        <= '0;
      active_count        <= '0;
      active_count_before <= '0;
      inactive_count      <= '0;
      repeat_phase        <= '0;
    end else if (accept) begin
      level_now           <= level_now_next;
      level_before        <= level_before_next;
      active_count        <= active_count_next;
      active_count_before <= active_count_before_next;
      inactive_count      <= inactive_count_next;
      repeat_phase        <= repeat_phase_next;
    end else if (div_status.done) begin
      repeat_phase <= div_remainder;
    end
  end

  // --------------------------------------------------------------------------
  // Output queue. A request only enters while the skid entry is empty; its
  // result goes straight to the output register when that is free or being
  // taken, and to the skid entry otherwise.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (take) begin
        skid_valid <= 1'b0;
      end
    end else if (accept) begin
      if (out_valid && !take) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (take) begin
        out_reg <= skid;
      end
    end else if (accept) begin
      if (out_valid && !take) begin
        skid <= result;
      end else begin
        out_reg <= result;
      end
    end
  end

  assign clicked        = out_reg.clicked;
  assign held           = out_reg.held;
  assign pulsed         = out_reg.pulsed;
  assign released       = out_reg.released;
  assign ticks_active   = out_reg.ticks_active;
  assign ticks_inactive = out_reg.ticks_inactive;

endmodule

// ===== rtl/kaq_checker.sv =====
// ----------------------------------------------------------------------------
// Key auto-repeat qualifier: port checker
// Checks relations between result fields and the output handshake.
// ----------------------------------------------------------------------------
`include "key_autorepeat_qualifier_top_defines.svh"

module kaq_checker import kaq_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic                  clicked,
  input logic                  pulsed,
  input logic                  released,
  input logic [CFG_BITS-1:0]   ticks_active,
  input logic [CFG_BITS-1:0]   ticks_inactive
);

  // Every click is also a pulse.
  `KAQ_ASSERT_NOW(a_click_pulses, out_valid && clicked, pulsed, "click without pulse")

  // A press edge and a release edge cannot share a result.
  `KAQ_ASSERT_NOW(a_click_release, out_valid, !(clicked && released), "click and release")

  // A click restarts the active count.
  `KAQ_ASSERT_NOW(a_click_count, out_valid && clicked, ticks_active == '0, "click count")

  // The active and inactive counts are never both running.
  `KAQ_ASSERT_NOW(a_one_count, out_valid, (ticks_active == '0) || (ticks_inactive == '0), "counts")

  // A stalled result stays offered.
  `KAQ_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped")

endmodule

bind key_autorepeat_qualifier_top kaq_checker u_kaq_checker (.*);
